// ===== sv/wsp_pkg.sv =====
// Shared types and constants of the whitespace integer list parser.
// Holds the result word layout, the queue hand-over struct and the character codes.
// Depends on nothing; used by wsp_parser, wsp_out_queue and the top level.
package wsp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ParsedW  = 32;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CountW-1:0] CountReset = 8'd3;

  // Character codes
  localparam logic [ByteW-1:0] ChTab     = 8'h09;
  localparam logic [ByteW-1:0] ChNewline = 8'h0A;
  localparam logic [ByteW-1:0] ChCr      = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus   = 8'h2D;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;

  // One result word as it leaves the block
  typedef struct packed {
    logic [ParsedW-1:0] value;
    logic [CountW-1:0]  index;
    logic               is_value;
    logic               success;
    logic               last;
  } result_t;

  // Words produced by one input word: count is 0, 1 or 2, first goes out first
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

// ===== sv/whitespace_integer_list_parser.sv =====
// Top level of the whitespace-separated decimal integer list parser.
// Depends on wsp_pkg, wsp_parser and wsp_out_queue.
//
// Usage:
//   Input stream: one text character per word in s_axis_tdata[7:0]; a word with
//   s_axis_tlast high is the end of text (its data is ignored) and closes the line.
//   Output stream: one word per parsed value, then a status word with tlast high.
//   m_axis_tdata holds parsed_value [31:0] and value_index [39:32]; m_axis_tuser
//   holds is_value [0] and success [1]. The status word carries the number of
//   values emitted in value_index.
//   Config channel: cfg_data_i sets count_wanted (values per line); always ready.
//   Write it only while the block is idle.
// Throughput:
//   One character per cycle while s_axis_tready is high. Results of a taken
//   word are written into the output queue. The end word may yield two results;
//   the four-entry output queue absorbs them and drains at one word per cycle
//   while m_axis_tready is high. s_axis_tready drops while fewer than two entries
//   are free, so a stalled receiver backs input up after at most four pending results.
// Reset:
//   rst_ni low empties the queue, clears the line state and sets count_wanted to 3.
module whitespace_integer_list_parser #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_COUNT  = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,    // count_wanted [7:0]
  // text in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // text_byte [7:0]
  input  logic        s_axis_tlast,  // end_of_text
  // results out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // parsed_value [31:0], value_index [39:32]
  output logic [1:0]  m_axis_tuser,  // is_value [0], success [1]
  output logic        m_axis_tlast   // last
);

  wsp_pkg::push_t   push;
  wsp_pkg::result_t head;
  logic             room;
  logic             in_take;
  logic             cfg_take;

  // configuration is always taken at once
  assign cfg_ready_o   = 1'b1;
  assign cfg_take      = cfg_valid_i && cfg_ready_o;

  // hold the input while the queue cannot take two more words
  assign s_axis_tready = room;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  wsp_parser #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_COUNT  (MAX_COUNT)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_take),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_take),
    .in_byte_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .push_o      (push)
  );

  wsp_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room_o  (room)
  );

  // unpack the head word onto the output channel
  assign m_axis_tdata = {head.index, head.value};
  assign m_axis_tuser = {head.success, head.is_value};
  assign m_axis_tlast = head.last;

endmodule

// ===== sv/wsp_parser.sv =====
// Per-character parse state and result generation of the integer list parser.
// Holds the count register, token accumulator and line state; emits up to two words.
// Depends on wsp_pkg.
module wsp_parser #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_COUNT  = 255
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [wsp_pkg::CountW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic [wsp_pkg::ByteW-1:0]  in_byte_i,
  input  logic                       in_end_i,
  output wsp_pkg::push_t             push_o
);

  localparam int unsigned AccW  = VALUE_BITS;
  localparam int unsigned ProdW = VALUE_BITS + 4;
  localparam int unsigned ExtW  = (VALUE_BITS > wsp_pkg::ParsedW) ? VALUE_BITS
                                                                  : wsp_pkg::ParsedW;
  localparam logic [AccW-1:0] Cap    = AccW'(1) << (AccW - 1);
  localparam logic [AccW-1:0] CapPos = Cap - AccW'(1);
  localparam logic [wsp_pkg::CountW-1:0] CountCap =
    (MAX_COUNT < 255) ? wsp_pkg::CountW'(MAX_COUNT) : 8'd255;

  localparam logic [1:0] PhSkip   = 2'd0;
  localparam logic [1:0] PhToken  = 2'd1;
  localparam logic [1:0] PhFailed = 2'd2;

  logic [1:0]                 phase_q, phase_d;
  logic                       fresh_q, fresh_d;
  logic [AccW-1:0]            acc_q, acc_d;
  logic                       neg_q, neg_d;
  logic                       stop_q, stop_d;
  logic [wsp_pkg::CountW-1:0] found_q, found_d;
  logic [wsp_pkg::CountW-1:0] count_q, count_d;

  logic [wsp_pkg::CountW-1:0] eff;
  logic [wsp_pkg::CountW-1:0] found_inc;
  logic                       done;
  logic [3:0]                 dig;
  logic [ProdW-1:0]           prod;
  logic [AccW-1:0]            acc_step;
  logic signed [AccW-1:0]     tok_sv;
  logic signed [ExtW-1:0]     tok_ext;
  logic [wsp_pkg::ParsedW-1:0] tok_val;
  logic                       has_value;
  logic                       ok;
  wsp_pkg::result_t           val_word;
  wsp_pkg::result_t           stat_word;

  assign eff       = (count_q > CountCap) ? CountCap : count_q;
  assign found_inc = found_q + 8'd1;
  assign done      = (found_q >= eff);

  // acc*10 + digit, saturate at the magnitude cap
  assign dig      = in_byte_i[3:0];
  assign prod     = (ProdW'(acc_q) << 3) + (ProdW'(acc_q) << 1) + ProdW'(dig);
  assign acc_step = (prod > ProdW'(Cap)) ? Cap : prod[AccW-1:0];

  assign tok_sv  = neg_q ? $signed(AccW'(0) - acc_q)
                         : $signed((acc_q > CapPos) ? CapPos : acc_q);
  assign tok_ext = ExtW'(tok_sv);
  assign tok_val = tok_ext[wsp_pkg::ParsedW-1:0];

  always_comb begin
    phase_d   = phase_q;
    fresh_d   = fresh_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    stop_d    = stop_q;
    found_d   = found_q;
    count_d   = count_q;
    has_value = 1'b0;
    ok        = 1'b0;
    push_o    = '0;

    val_word          = '0;
    val_word.index    = found_q;
    val_word.is_value = 1'b1;
    stat_word         = '0;
    stat_word.last    = 1'b1;

    if (cfg_valid_i) begin
      count_d = cfg_data_i;
    end

    if (in_valid_i && in_end_i) begin
      if (phase_q == PhFailed) begin
        ok = 1'b0;
      end else if (done) begin
        ok = 1'b1;
      end else if ((phase_q == PhToken) || !fresh_q) begin
        has_value      = 1'b1;
        val_word.value = (phase_q == PhToken) ? tok_val : '0;
        ok             = (found_inc >= eff);
      end else begin
        ok = 1'b0;
      end
      stat_word.index   = has_value ? found_inc : found_q;
      stat_word.success = ok;
      if (has_value) begin
        push_o.count  = 2'd2;
        push_o.first  = val_word;
        push_o.second = stat_word;
      end else begin
        push_o.count = 2'd1;
        push_o.first = stat_word;
      end
      // close the line
      phase_d = PhSkip;
      fresh_d = 1'b1;
      found_d = '0;
      acc_d   = '0;
      neg_d   = 1'b0;
      stop_d  = 1'b0;
    end else if (in_valid_i && (phase_q != PhFailed) && !done) begin
      if (phase_q == PhSkip) begin
        if (in_byte_i == wsp_pkg::ChNewline) begin
          phase_d = PhFailed;
        end else if (wsp_pkg::is_space(in_byte_i)) begin
          fresh_d = 1'b0;
        end else begin
          // first character of a token: sign, digit or stop
          phase_d = PhToken;
          neg_d   = (in_byte_i == wsp_pkg::ChMinus);
          acc_d   = wsp_pkg::is_digit(in_byte_i) ? AccW'(dig) : '0;
          stop_d  = !wsp_pkg::is_digit(in_byte_i) && (in_byte_i != wsp_pkg::ChMinus) &&
                    (in_byte_i != wsp_pkg::ChPlus);
        end
      end else if (wsp_pkg::is_space(in_byte_i)) begin
        // separator: emit the token, drop back to skipping
        val_word.value = tok_val;
        push_o.count   = 2'd1;
        push_o.first   = val_word;
        found_d        = found_inc;
        phase_d        = PhSkip;
        fresh_d        = 1'b1;
        acc_d          = '0;
        neg_d          = 1'b0;
        stop_d         = 1'b0;
      end else if (!stop_q) begin
        if (wsp_pkg::is_digit(in_byte_i)) begin
          acc_d = acc_step;
        end else begin
          stop_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      fresh_q <= 1'b1;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      stop_q  <= 1'b0;
      found_q <= '0;
      count_q <= wsp_pkg::CountReset;
    end else begin
      phase_q <= phase_d;
      fresh_q <= fresh_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      stop_q  <= stop_d;
      found_q <= found_d;
      count_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pair_is_value_then_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (push_o.first.is_value && push_o.second.last))
    else $error("two words must be a value followed by the status word");

  a_status_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_end_i) |-> (push_o.count <= 2'd1 && !push_o.first.last))
    else $error("status word without end of text");

  a_failed_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhFailed && !(in_valid_i && in_end_i)) |=> (phase_q == PhFailed))
    else $error("failed line left before end of text");
`endif

endmodule

// ===== sv/wsp_out_queue.sv =====
// Four-entry result queue between the parser and the output channel.
// Takes up to two words a cycle, releases one word a cycle from its head while pop_i is high.
// Depends on wsp_pkg.
module wsp_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wsp_pkg::push_t   push_i,
  input  logic             pop_i,
  output wsp_pkg::result_t head_o,
  output logic             valid_o,
  output logic             room_o
);

  localparam int unsigned Depth = wsp_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  wsp_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = pop_i && valid_o;

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> ((cnt_q + CntW'(push_i.count)) <= CntW'(Depth)))
    else $error("result queue overflow");

  a_pointer_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != CntW'(Depth)) |-> (PtrW'(wr_ptr_q - rd_ptr_q) == PtrW'(cnt_q)))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== tb/whitespace_integer_list_parser_checker.sv =====
// Checker for the whitespace integer list parser: watches the config, text and result channels.
// Predicts the result words of every accepted text word and compares them field by field.
// Depends on wsp_pkg for the result layout, the count reset value and the character codes.
`timescale 1ns / 1ps

module whitespace_integer_list_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,   // text_byte [7:0]
  input  logic        s_last_i,   // end_of_text
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,   // parsed_value [31:0], value_index [39:32]
  input  logic [1:0]  m_user_i,   // is_value [0], success [1]
  input  logic        m_last_i,
  output int          errors_o,
  output int          due_count_o
);

  typedef enum logic [1:0] {PhaseSkip, PhaseToken, PhaseFailed} phase_e;

  localparam longint unsigned Cap = 64'd1 << 31;

  phase_e           phase_q;
  logic             fresh_q;
  logic             minus_q;
  logic             halted_q;
  logic             begun_q;
  longint unsigned  magnitude_q;
  logic [7:0]       found_q;
  logic [7:0]       wanted_q;
  wsp_pkg::result_t values_due[$];

  function automatic logic is_blank(input logic [7:0] c);
    return (c == wsp_pkg::ChSpace) || ((c >= wsp_pkg::ChTab) && (c <= wsp_pkg::ChCr));
  endfunction

  function automatic void clear_token();
    magnitude_q = 0;
    minus_q     = 1'b0;
    halted_q    = 1'b0;
    begun_q     = 1'b0;
  endfunction

  function automatic void restart_line();
    phase_q = PhaseSkip;
    fresh_q = 1'b1;
    found_q = '0;
    clear_token();
  endfunction

  // Signed value of the token so far, clipped to the 32-bit range
  function automatic logic [31:0] token_value();
    longint unsigned mag;
    mag = magnitude_q;
    if (minus_q) begin
      if (mag > Cap) mag = Cap;
      return 32'(64'd0 - mag);
    end
    if (mag > Cap - 1) mag = Cap - 1;
    return 32'(mag);
  endfunction

  function automatic void queue_word(input logic [31:0] value, input logic [7:0] index,
                                     input logic is_value, input logic success,
                                     input logic last);
    wsp_pkg::result_t w;
    w.value    = value;
    w.index    = index;
    w.is_value = is_value;
    w.success  = success;
    w.last     = last;
    values_due.push_back(w);
  endfunction

  // Sign only as the first token character; the first non-digit stops the digits
  function automatic void absorb_char(input logic [7:0] c);
    longint unsigned digit;
    if (!begun_q) begin
      begun_q = 1'b1;
      if (c == wsp_pkg::ChMinus) begin
        minus_q = 1'b1;
        return;
      end
      if (c == wsp_pkg::ChPlus) return;
    end
    if (halted_q) return;
    if ((c < wsp_pkg::ChZero) || (c > wsp_pkg::ChNine)) begin
      halted_q = 1'b1;
      return;
    end
    digit = c - wsp_pkg::ChZero;
    if (magnitude_q > (Cap - digit) / 10) magnitude_q = Cap;
    else magnitude_q = magnitude_q * 10 + digit;
  endfunction

  function automatic void parse_text_word(input logic [7:0] c, input logic eot);
    logic ok;
    if (eot) begin
      if (phase_q == PhaseFailed) begin
        ok = 1'b0;
      end else if (found_q >= wanted_q) begin
        ok = 1'b1;
      end else if ((phase_q == PhaseToken) || !fresh_q) begin
        // trailing whitespace stands as a token of value zero
        queue_word((phase_q == PhaseToken) ? token_value() : 32'd0, found_q, 1'b1, 1'b0, 1'b0);
        found_q++;
        ok = (found_q >= wanted_q);
      end else begin
        ok = 1'b0;
      end
      queue_word(32'd0, found_q, 1'b0, ok, 1'b1);
      restart_line();
      return;
    end
    if ((phase_q == PhaseFailed) || (found_q >= wanted_q)) return;
    if (phase_q == PhaseSkip) begin
      if (c == wsp_pkg::ChNewline) phase_q = PhaseFailed;
      else if (is_blank(c)) fresh_q = 1'b0;
      else begin
        clear_token();
        phase_q = PhaseToken;
        absorb_char(c);
      end
      return;
    end
    if (is_blank(c)) begin
      queue_word(token_value(), found_q, 1'b1, 1'b0, 1'b0);
      found_q++;
      phase_q = PhaseSkip;
      fresh_q = 1'b1;
      clear_token();
      return;
    end
    absorb_char(c);
  endfunction

  function automatic void compare_word();
    wsp_pkg::result_t want;
    if (values_due.size() == 0) begin
      $error("result word with none due: value %0d index %0d", $signed(m_data_i[31:0]),
             m_data_i[39:32]);
      errors_o++;
      return;
    end
    want = values_due.pop_front();
    if (m_data_i[31:0] !== want.value) begin
      $error("parsed_value: expected %0d, got %0d", $signed(want.value), $signed(m_data_i[31:0]));
      errors_o++;
    end
    if (m_data_i[39:32] !== want.index) begin
      $error("value_index: expected %0d, got %0d", want.index, m_data_i[39:32]);
      errors_o++;
    end
    if (m_user_i[0] !== want.is_value) begin
      $error("is_value: expected %0d, got %0d", want.is_value, m_user_i[0]);
      errors_o++;
    end
    if (m_user_i[1] !== want.success) begin
      $error("success: expected %0d, got %0d", want.success, m_user_i[1]);
      errors_o++;
    end
    if (m_last_i !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, m_last_i);
      errors_o++;
    end
  endfunction

  // A result taken at this edge comes from an earlier word, so compare first
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q = wsp_pkg::CountReset;
      restart_line();
      values_due.delete();
      errors_o    = 0;
      due_count_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) compare_word();
      if (cfg_valid_i && cfg_ready_i) wanted_q = cfg_data_i;
      if (s_valid_i && s_ready_i) parse_text_word(s_data_i, s_last_i);
      due_count_o = values_due.size();
    end
  end

endmodule

// ===== tb/whitespace_integer_list_parser_tb.sv =====
// Top of the testbench for the whitespace integer list parser: clock, reset, stimulus, verdict.
// Drives text lines and count settings, idles both streams; the checker does the comparing.
// Depends on wsp_pkg, whitespace_integer_list_parser and whitespace_integer_list_parser_checker.
`timescale 1ns / 1ps

module whitespace_integer_list_parser_tb;

  // Cycles to let pass once nothing is due
  localparam int SettleCycles = 4;
  localparam int DrainCycles  = 8;
  // Slowest run: ~650 words, each after the longest idle gap, with two results held by the longest stall
  localparam int CycleLimit   = 500000;
  localparam int WordTarget   = 600;

  localparam logic [7:0] VertTab  = 8'h0B;
  localparam logic [7:0] FormFeed = 8'h0C;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int         errors;
  int         due_count;
  int         cycle_count = 0;
  int         words_sent  = 0;
  int         stall_left  = 0;
  int         reply_gap;
  int         phase;
  logic       calm = 1'b0;
  logic [7:0] line_buf[$];

  whitespace_integer_list_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  whitespace_integer_list_parser_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .m_last_i    (m_axis_tlast),
    .errors_o    (errors),
    .due_count_o (due_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case a word is never taken or a result never shows
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Idle length for either stream: mostly none, some short, a few long.
  // A calm line gets none at all.
  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: drop tready for a random stretch, then hold it high
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else begin
      reply_gap = idle_gap();
      if (reply_gap > 0) begin
        stall_left    = reply_gap - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Present one word at a falling edge and hold it until it is taken.
  // tvalid stays high on return so a back-to-back word is not lowered in between.
  task automatic send_word(input logic [7:0] c, input logic eot);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = eot;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Send the buffered characters, then the end word with junk in its data
  task automatic send_line();
    foreach (line_buf[i]) send_word(line_buf[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Change count_wanted only once every due result is out and the block has settled
  task automatic write_count(input logic [7:0] count);
    s_axis_tvalid = 1'b0;
    while (due_count != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = count;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Whitespace run; a newline is common as the first character (the separator after a
  // token, a failure at the line start) and rare further on, where it fails the line
  task automatic add_blanks(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < ((i == 0) ? 15 : 4)) line_buf.push_back(wsp_pkg::ChNewline);
      else begin
        case ($urandom_range(0, 4))
          0:       line_buf.push_back(wsp_pkg::ChTab);
          1:       line_buf.push_back(VertTab);
          2:       line_buf.push_back(FormFeed);
          3:       line_buf.push_back(wsp_pkg::ChCr);
          default: line_buf.push_back(wsp_pkg::ChSpace);
        endcase
      end
    end
  endtask

  // One token: optional sign, then digits near the 32-bit limit, a long run that may
  // saturate, or a short run; now and then a stray non-blank byte before or after
  task automatic add_token();
    int         kind;
    int         digits;
    int         stray;
    string      txt;
    logic [7:0] junk;
    kind  = $urandom_range(0, 9);
    stray = $urandom_range(0, 11);
    do junk = 8'($urandom_range(0, 255)); while (wsp_pkg::is_space(junk));
    case ($urandom_range(0, 9))
      0, 1:    line_buf.push_back(wsp_pkg::ChMinus);
      2:       line_buf.push_back(wsp_pkg::ChPlus);
      default: ;
    endcase
    if (stray == 0) line_buf.push_back(junk);
    if (kind == 0) begin
      txt = $sformatf("%0d", 64'd2147483646 + $urandom_range(0, 3));
      foreach (txt[i]) line_buf.push_back(txt[i]);
    end else begin
      digits = (kind == 1) ? $urandom_range(10, 14) : $urandom_range(1, 4);
      repeat (digits) line_buf.push_back(wsp_pkg::ChZero + 8'($urandom_range(0, 9)));
    end
    if (stray == 1) line_buf.push_back(junk);
  endtask

  // Mostly well-formed lines with random content; the rest pure noise bytes
  task automatic build_line(input int wanted);
    int ntok;
    line_buf.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) add_blanks($urandom_range(1, 2));
    ntok = $urandom_range(0, (wanted > 4) ? 5 : wanted + 1);
    for (int i = 0; i < ntok; i++) begin
      add_token();
      if ((i < ntok - 1) || ($urandom_range(0, 3) == 0)) add_blanks($urandom_range(1, 3));
    end
  endtask

  initial begin
    logic [7:0] count;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed lines at the reset count of three
    line_buf = '{wsp_pkg::ChNewline};          // newline before any token fails
    send_line();
    // newline as separator, a zero byte as token, end inside a token
    line_buf = '{wsp_pkg::ChPlus, wsp_pkg::ChZero + 8'd1, wsp_pkg::ChNewline, 8'h00,
                 wsp_pkg::ChSpace, wsp_pkg::ChZero + 8'd9};
    send_line();
    line_buf = '{wsp_pkg::ChSpace};            // trailing whitespace yields zero
    send_line();
    // sign mid-token
    line_buf = '{wsp_pkg::ChZero + 8'd7, wsp_pkg::ChMinus, wsp_pkg::ChZero + 8'd3,
                 wsp_pkg::ChTab, 8'hFF};
    send_line();
    write_count(8'd0);                         // nothing wanted: success at once
    line_buf = '{wsp_pkg::ChZero + 8'd5};
    send_line();
    write_count(8'd1);                         // count reached: drop the rest
    line_buf = '{wsp_pkg::ChZero + 8'd1, wsp_pkg::ChZero + 8'd2, wsp_pkg::ChSpace,
                 wsp_pkg::ChZero + 8'd3, wsp_pkg::ChZero + 8'd4};
    send_line();

    // Random phases, each at its own count setting, extremes among them
    phase = 0;
    while (words_sent < WordTarget) begin
      case (phase % 6)
        0:       count = 8'd255;
        1:       count = 8'd0;
        2:       count = 8'd1;
        5:       count = 8'($urandom_range(0, 255));
        default: count = 8'($urandom_range(2, 6));
      endcase
      write_count(count);
      repeat ($urandom_range(4, 10)) begin
        if (words_sent < WordTarget) begin
          calm = ($urandom_range(0, 5) == 0);
          build_line(count);
          send_line();
        end
      end
      phase++;
    end

    calm          = 1'b0;
    s_axis_tvalid = 1'b0;
    while (due_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
sv/wsp_pkg.sv
sv/wsp_parser.sv
sv/wsp_out_queue.sv
sv/whitespace_integer_list_parser.sv
tb/whitespace_integer_list_parser_checker.sv
tb/whitespace_integer_list_parser_tb.sv
